// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the first-fit bitmap block
// allocator: sizes of the free map, status and command codes, controller
// states and the control records passed between controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int NUM_BLOCKS = 1024;

	localparam int IDX_W   = 10;
	localparam int CNT_W   = 11;
	localparam int STAT_W  = 3;
	localparam int WORD_W  = 32;
	localparam int BIT_W   = 5;
	localparam int WADDR_W = IDX_W - BIT_W;

	// The limit can never exceed the index span, and is a whole number of bytes.
	localparam int CAP_RAW   = (NUM_BLOCKS > (1 << IDX_W)) ? (1 << IDX_W) : NUM_BLOCKS;
	localparam int BLOCK_CAP = (CAP_RAW / 8) * 8;
	localparam int NUM_WORDS = (BLOCK_CAP + WORD_W - 1) / WORD_W;

	localparam logic [CNT_W-1:0] LIMIT_CAP   = CNT_W'(BLOCK_CAP);
	localparam logic [CNT_W-1:0] RESET_TOTAL = CNT_W'(1024);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_ALLOCATED    = 3'd0,
		STAT_NONE_FREE    = 3'd1,
		STAT_FREED        = 3'd2,
		STAT_OUT_OF_RANGE = 3'd3,
		STAT_ALREADY_FREE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic find;
		logic read;
		logic update;
	} ctrl_cmd_t;

	typedef struct packed {
		logic early_fail;
	} dp_stat_t;

	// Clears the low three bits and saturates at the capacity.
	function automatic logic [CNT_W-1:0] bound_limit(input logic [CNT_W-1:0] total);
		logic [CNT_W-1:0] lim;
		lim = {total[CNT_W-1:3], 3'b000};
		if (lim > LIMIT_CAP) begin
			lim = LIMIT_CAP;
		end
		return lim;
	endfunction

endpackage

// File: src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit bitmap block allocator: allocates the lowest free block below
// the limit, frees used blocks, and formats the map when the block total is
// written.
//
//   Channel   Handshake            Payload
//   request   start, busy          command, target_block
//   result    done (1-cycle)       allocated_index, status, free_count
//   config    cfg_wen              cfg_wdata (block total)
//
// A request steps through the word search, the bitmap word read and the
// update, or ends at the search when it fails there (nothing free, index
// out of range); the single-port bitmap word memory sets these steps. busy is
// low only in idle. The result shows in the cycle after the last step, and
// the receiver cannot stall. Reset and a configuration write format the map
// at once through per-word valid flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [bba_pkg::IDX_W-1:0]   target_block,
	input  logic                        cfg_wen,
	input  logic [bba_pkg::CNT_W-1:0]   cfg_wdata,
	output logic                        done,
	output logic [bba_pkg::IDX_W-1:0]   allocated_index,
	output logic [bba_pkg::STAT_W-1:0]  status,
	output logic [bba_pkg::CNT_W-1:0]   free_count
);

	bba_pkg::ctrl_cmd_t cmd;
	bba_pkg::dp_stat_t  stat;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	bba_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.command         (command),
		.target_block    (target_block),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.allocated_index (allocated_index),
		.status          (status),
		.free_count      (free_count)
	);

endmodule

// File: src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: accepts a request, steps the datapath through
// the word search, the bitmap read and the update, and finishes early when
// the datapath reports that the request fails without touching the bitmap.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output bba_pkg::ctrl_cmd_t cmd,
	input  bba_pkg::dp_stat_t  stat
);

	bba_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = bba_pkg::ST_FIND;
				end
			end
			bba_pkg::ST_FIND: begin
				state_nxt = stat.early_fail ? bba_pkg::ST_IDLE : bba_pkg::ST_READ;
			end
			bba_pkg::ST_READ:   state_nxt = bba_pkg::ST_UPDATE;
			bba_pkg::ST_UPDATE: state_nxt = bba_pkg::ST_IDLE;
			default:            state_nxt = bba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			bba_pkg::ST_FIND:   cmd.find   = 1'b1;
			bba_pkg::ST_READ:   cmd.read   = 1'b1;
			bba_pkg::ST_UPDATE: cmd.update = 1'b1;
			default:            busy       = 1'b1;
		endcase
	end

endmodule

// File: src/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Free map held as a memory of 32-bit words, with a row-valid flag per word
// (an unwritten word reads as all free) and a per-word flag telling whether
// the word still holds a free block below the limit. Also holds the limit,
// the free counter and the result registers.
// ----------------------------------------------------------------------------
module bba_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bba_pkg::ctrl_cmd_t          cmd,
	output bba_pkg::dp_stat_t           stat,
	input  logic                        command,
	input  logic [bba_pkg::IDX_W-1:0]   target_block,
	input  logic                        cfg_wen,
	input  logic [bba_pkg::CNT_W-1:0]   cfg_wdata,
	output logic                        done,
	output logic [bba_pkg::IDX_W-1:0]   allocated_index,
	output logic [bba_pkg::STAT_W-1:0]  status,
	output logic [bba_pkg::CNT_W-1:0]   free_count
);

	localparam int NW = bba_pkg::NUM_WORDS;
	localparam int WW = bba_pkg::WORD_W;
	localparam int AW = bba_pkg::WADDR_W;
	localparam int BW = bba_pkg::BIT_W;
	localparam int CW = bba_pkg::CNT_W;

	// Words that start below the limit hold at least one usable free block.
	function automatic logic [NW-1:0] word_flags(input logic [CW-1:0] lim);
		logic [NW-1:0] flags;
		for (int w = 0; w < NW; w++) begin
			flags[w] = (CW'(w * WW) < lim);
		end
		return flags;
	endfunction

	logic [WW-1:0] mem [NW];

	logic                    req_cmd_q;
	logic [bba_pkg::IDX_W-1:0] req_idx_q;
	logic [CW-1:0]           limit_q;
	logic [CW-1:0]           free_cnt_q;
	logic [NW-1:0]           row_valid_q;
	logic [NW-1:0]           word_free_q;
	logic [AW-1:0]           waddr_q;
	logic [WW-1:0]           rd_data_q;
	logic                    row_ok_q;

	logic                    done_q;
	logic [bba_pkg::IDX_W-1:0] alloc_idx_q;
	bba_pkg::status_t        status_q;
	logic [CW-1:0]           count_q;

	logic [AW-1:0]  first_word;
	logic           any_word;
	logic           is_alloc;
	logic           early_fail;
	logic [AW-1:0]  find_addr;
	logic [WW-1:0]  eff_word;
	logic [WW-1:0]  lim_mask;
	logic [WW-1:0]  avail;
	logic [BW-1:0]  low_bit;
	logic [BW-1:0]  bit_sel;
	logic [WW-1:0]  bit_onehot;
	logic [WW-1:0]  new_word;
	logic           already_free;
	logic           do_write;
	logic [CW-1:0]  cnt_next;
	logic [CW-1:0]  new_limit;

	assign is_alloc = (req_cmd_q == bba_pkg::CMD_ALLOC);

	always_comb begin
		first_word = '0;
		any_word   = 1'b0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (word_free_q[i]) begin
				first_word = AW'(i);
				any_word   = 1'b1;
			end
		end
	end

	always_comb begin
		if (is_alloc) begin
			early_fail = (free_cnt_q == '0) || !any_word;
			find_addr  = first_word;
		end else begin
			early_fail = ({1'b0, req_idx_q} >= limit_q);
			find_addr  = req_idx_q[bba_pkg::IDX_W-1:BW];
		end
	end

	assign stat.early_fail = early_fail;

	// Update stage: blocks at or above the limit are never handed out.
	assign eff_word = row_ok_q ? rd_data_q : '1;

	always_comb begin
		if ({1'b0, waddr_q} < limit_q[CW-1:BW]) begin
			lim_mask = '1;
		end else if ({1'b0, waddr_q} == limit_q[CW-1:BW]) begin
			lim_mask = ~({WW{1'b1}} << limit_q[BW-1:0]);
		end else begin
			lim_mask = '0;
		end
	end

	assign avail = eff_word & lim_mask;

	always_comb begin
		low_bit = '0;
		for (int i = WW - 1; i >= 0; i--) begin
			if (avail[i]) begin
				low_bit = BW'(i);
			end
		end
	end

	assign bit_sel      = is_alloc ? low_bit : req_idx_q[BW-1:0];
	assign bit_onehot   = WW'(1) << bit_sel;
	assign new_word     = is_alloc ? (eff_word & ~bit_onehot) : (eff_word | bit_onehot);
	assign already_free = eff_word[req_idx_q[BW-1:0]];
	assign do_write     = cmd.update && (is_alloc || !already_free);
	assign cnt_next     = is_alloc ? (free_cnt_q - CW'(1)) : (free_cnt_q + CW'(1));
	assign new_limit    = bba_pkg::bound_limit(cfg_wdata);

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_data_q <= mem[waddr_q];
			row_ok_q  <= row_valid_q[waddr_q];
		end
		if (do_write) begin
			mem[waddr_q] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_cmd_q <= command;
			req_idx_q <= target_block;
		end
		if (cmd.find) begin
			waddr_q <= find_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= bba_pkg::bound_limit(bba_pkg::RESET_TOTAL);
			free_cnt_q  <= bba_pkg::bound_limit(bba_pkg::RESET_TOTAL);
			row_valid_q <= '0;
			word_free_q <= word_flags(bba_pkg::bound_limit(bba_pkg::RESET_TOTAL));
		end else if (cfg_wen) begin
			limit_q     <= new_limit;
			free_cnt_q  <= new_limit;
			row_valid_q <= '0;
			word_free_q <= word_flags(new_limit);
		end else if (do_write) begin
			free_cnt_q           <= cnt_next;
			row_valid_q[waddr_q] <= 1'b1;
			word_free_q[waddr_q] <= is_alloc ? |(new_word & lim_mask) : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.find && early_fail) || cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find && early_fail) begin
			alloc_idx_q <= '0;
			status_q    <= is_alloc ? bba_pkg::STAT_NONE_FREE : bba_pkg::STAT_OUT_OF_RANGE;
			count_q     <= free_cnt_q;
		end else if (cmd.update) begin
			if (is_alloc) begin
				alloc_idx_q <= {waddr_q, low_bit};
				status_q    <= bba_pkg::STAT_ALLOCATED;
				count_q     <= cnt_next;
			end else if (already_free) begin
				alloc_idx_q <= '0;
				status_q    <= bba_pkg::STAT_ALREADY_FREE;
				count_q     <= free_cnt_q;
			end else begin
				alloc_idx_q <= '0;
				status_q    <= bba_pkg::STAT_FREED;
				count_q     <= cnt_next;
			end
		end
	end

	assign done            = done_q;
	assign allocated_index = alloc_idx_q;
	assign status          = status_q;
	assign free_count      = count_q;

	// The free counter can never exceed the number of managed blocks.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= limit_q)
		else $error("free counter above limit");

	// A word picked by the search must really hold a free block below the limit.
	a_alloc_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && is_alloc |-> avail != '0)
		else $error("allocate found no free block in the selected word");

	// Only a successful allocate reports a non-zero index.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != bba_pkg::STAT_ALLOCATED |-> alloc_idx_q == '0)
		else $error("index reported for a non-allocate result");

	// A request that fails at the search (out-of-range free, nothing to allocate) leaves the counter untouched.
	a_range_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find && early_fail && !cfg_wen |=> $stable(free_cnt_q))
		else $error("failed request changed the free counter");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit bitmap block allocator. The bench
// keeps its own copy of the free map, free count and limit, predicts each
// request's result as the item is accepted, and checks every result strobe
// against the oldest prediction. Directed tests cover the reset state, a zero
// limit and a full map, then random phases run at several limits and idle
// rates, with each block total write made while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDX_W       = bba_pkg::IDX_W;
	localparam int CNT_W       = bba_pkg::CNT_W;
	localparam int STAT_W      = bba_pkg::STAT_W;
	localparam int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS;
	localparam int BLOCK_CAP   = bba_pkg::BLOCK_CAP;

	typedef struct {
		logic [IDX_W-1:0] index;
		bba_pkg::status_t stat;
		logic [CNT_W-1:0] count;
	} alloc_result_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic              command      = bba_pkg::CMD_ALLOC;
	logic [IDX_W-1:0]  target_block = '0;
	logic              cfg_wen      = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata    = '0;
	logic              busy;
	logic              done;
	logic [IDX_W-1:0]  allocated_index;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  free_count;

	// Bench copy of the allocator state.
	logic [NUM_BLOCKS-1:0] free_bits;
	logic [CNT_W-1:0]      free_total;
	logic [CNT_W-1:0]      block_limit;

	alloc_result_t expected_results[$];
	alloc_result_t expected_head;
	int            idle_pct    = 0;
	int            cycle_count = 0;
	bit            failed      = 1'b0;

	bitmap_block_allocator u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.target_block    (target_block),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.allocated_index (allocated_index),
		.status          (status),
		.free_count      (free_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL bitmap_block_allocator");
			$finish;
		end
	end

	// The limit drops the low three bits of the total and saturates at the capacity.
	function automatic void format_map(input logic [CNT_W-1:0] total);
		logic [CNT_W-1:0] lim;
		lim = total & ~CNT_W'(7);
		if (lim > CNT_W'(BLOCK_CAP)) begin
			lim = CNT_W'(BLOCK_CAP);
		end
		block_limit = lim;
		free_bits   = '1;
		free_total  = lim;
	endfunction

	function automatic alloc_result_t predict_request(input bba_pkg::command_t cmd,
			input logic [IDX_W-1:0] idx);
		alloc_result_t r;
		bit            found;
		r.index = '0;
		r.stat  = bba_pkg::STAT_NONE_FREE;
		found   = 1'b0;
		if (cmd == bba_pkg::CMD_ALLOC) begin
			if (free_total != 0) begin
				for (int i = 0; i < block_limit; i++) begin
					if (!found && free_bits[i]) begin
						found        = 1'b1;
						free_bits[i] = 1'b0;
						free_total   = free_total - 1'b1;
						r.index      = IDX_W'(i);
						r.stat       = bba_pkg::STAT_ALLOCATED;
					end
				end
			end
		end else if (CNT_W'(idx) >= block_limit) begin
			r.stat = bba_pkg::STAT_OUT_OF_RANGE;
		end else if (free_bits[idx]) begin
			r.stat = bba_pkg::STAT_ALREADY_FREE;
		end else begin
			free_bits[idx] = 1'b1;
			free_total     = free_total + 1'b1;
			r.stat         = bba_pkg::STAT_FREED;
		end
		r.count = free_total;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d allocated_index %0d", status,
					allocated_index);
				failed = 1'b1;
			end else begin
				expected_head = expected_results.pop_front();
				if (allocated_index !== expected_head.index) begin
					$error("allocated_index: expected %0d, got %0d", expected_head.index,
						allocated_index);
					failed = 1'b1;
				end
				if (status !== expected_head.stat) begin
					$error("status: expected %0d, got %0d", expected_head.stat, status);
					failed = 1'b1;
				end
				if (free_count !== expected_head.count) begin
					$error("free_count: expected %0d, got %0d", expected_head.count,
						free_count);
					failed = 1'b1;
				end
			end
		end
	end

	// start is left high after acceptance; the next call either keeps it or drops it.
	task automatic send_item(input bba_pkg::command_t cmd, input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		target_block <= idx;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_request(cmd, idx));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_total(input logic [CNT_W-1:0] total);
		wait_for_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= total;
		@(posedge clk);
		format_map(total);
		cfg_wen <= 1'b0;
	endtask

	task automatic test_reset_state();
		idle_pct = 0;
		send_item(bba_pkg::CMD_ALLOC, '0);
		send_item(bba_pkg::CMD_ALLOC, '1);
		send_item(bba_pkg::CMD_FREE, IDX_W'(1));
		send_item(bba_pkg::CMD_FREE, IDX_W'(1));
		send_item(bba_pkg::CMD_FREE, '1);
		send_item(bba_pkg::CMD_FREE, '0);
		send_item(bba_pkg::CMD_ALLOC, IDX_W'(10'h2AA));
	endtask

	task automatic test_zero_limit();
		// Seven rounds down to a zero limit.
		write_total(CNT_W'(7));
		send_item(bba_pkg::CMD_ALLOC, '0);
		send_item(bba_pkg::CMD_FREE, '0);
		send_item(bba_pkg::CMD_FREE, '1);
		write_total('0);
		send_item(bba_pkg::CMD_ALLOC, '1);
	endtask

	task automatic test_full_map();
		write_total(CNT_W'(8));
		idle_pct = 86;
		for (int i = 0; i < 9; i++) begin
			send_item(bba_pkg::CMD_ALLOC, (i % 2) ? IDX_W'(10'h155) : IDX_W'(10'h2AA));
		end
		send_item(bba_pkg::CMD_FREE, IDX_W'(8));
		send_item(bba_pkg::CMD_FREE, IDX_W'(7));
		send_item(bba_pkg::CMD_ALLOC, '0);
		send_item(bba_pkg::CMD_FREE, '1);
	endtask

	task automatic test_random(input logic [CNT_W-1:0] total, input int items, input int pct);
		bba_pkg::command_t cmd;
		logic [IDX_W-1:0]  idx;
		int                lim;
		int                base;
		bit                found;
		write_total(total);
		idle_pct = pct;
		lim      = int'(block_limit);
		for (int i = 0; i < items; i++) begin
			idx = IDX_W'($urandom);
			if ($urandom_range(99) < 55) begin
				cmd = bba_pkg::CMD_ALLOC;
			end else begin
				cmd = bba_pkg::CMD_FREE;
				// Mostly hand back a block in use so that the map keeps churning.
				if (lim != 0 && $urandom_range(99) < 70) begin
					base  = $urandom_range(lim - 1);
					found = 1'b0;
					for (int k = 0; k < lim; k++) begin
						if (!found && !free_bits[(base + k) % lim]) begin
							found = 1'b1;
							idx   = IDX_W'((base + k) % lim);
						end
					end
				end else if (lim != 0 && $urandom_range(1)) begin
					idx = IDX_W'($urandom_range(lim - 1));
				end
			end
			if ($urandom_range(39) == 0) begin
				wait_for_results();
			end
			send_item(cmd, idx);
		end
	endtask

	initial begin
		format_map(bba_pkg::RESET_TOTAL);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_zero_limit();
		test_full_map();
		test_random(CNT_W'(16), 130, 0);
		test_random(CNT_W'(2047), 120, 86);
		test_random(CNT_W'(1), 20, 36);
		test_random(CNT_W'(64), 130, 36);
		test_random(CNT_W'(1023), 100, 0);
		wait_for_results();
		if (!failed) begin
			$display("PASS bitmap_block_allocator");
		end else begin
			$display("FAIL bitmap_block_allocator");
		end
		$finish;
	end

endmodule
